// ----- design/pcode_stack_machine_execute_macros.svh -----
// Assertion helpers for the p-code stack machine.
`ifndef PCODE_STACK_MACHINE_EXECUTE_MACROS_SVH
`define PCODE_STACK_MACHINE_EXECUTE_MACROS_SVH

// same-cycle implication
`define PCSM_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCSM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pcsm_pkg.sv -----
// ---------------------------------------------------------------------------
// pcsm_pkg
// Widths, instruction codes and fault codes of the p-code stack machine.
// ---------------------------------------------------------------------------
package pcsm_pkg;

  localparam int STACK_DEPTH = 4096;
  localparam int AW          = 12;   // stack address bits
  localparam int WB          = 32;   // stack word bits
  localparam int PCW         = 11;   // program address bits
  localparam int TW          = 13;   // signed top index bits
  localparam int IW          = 34;   // signed working index bits
  localparam int DCW         = 5;    // divider step counter bits

  localparam logic [2:0] FC_LIT = 3'd0;
  localparam logic [2:0] FC_OPR = 3'd1;
  localparam logic [2:0] FC_LOD = 3'd2;
  localparam logic [2:0] FC_STO = 3'd3;
  localparam logic [2:0] FC_CAL = 3'd4;
  localparam logic [2:0] FC_INT = 3'd5;
  localparam logic [2:0] FC_JMP = 3'd6;
  localparam logic [2:0] FC_JPC = 3'd7;

  localparam logic [PCW-1:0] OPR_RET = 11'd0;
  localparam logic [PCW-1:0] OPR_NEG = 11'd1;
  localparam logic [PCW-1:0] OPR_ADD = 11'd2;
  localparam logic [PCW-1:0] OPR_SUB = 11'd3;
  localparam logic [PCW-1:0] OPR_MUL = 11'd4;
  localparam logic [PCW-1:0] OPR_DIV = 11'd5;
  localparam logic [PCW-1:0] OPR_ODD = 11'd6;
  localparam logic [PCW-1:0] OPR_EQ  = 11'd8;
  localparam logic [PCW-1:0] OPR_NE  = 11'd9;
  localparam logic [PCW-1:0] OPR_LT  = 11'd10;
  localparam logic [PCW-1:0] OPR_GE  = 11'd11;
  localparam logic [PCW-1:0] OPR_GT  = 11'd12;
  localparam logic [PCW-1:0] OPR_LE  = 11'd13;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_DIV  = 2'd1;
  localparam logic [1:0] FAULT_OVF  = 2'd2;
  localparam logic [1:0] FAULT_IDX  = 2'd3;

endpackage

// ----- design/pcode_stack_machine_execute.sv -----
// ---------------------------------------------------------------------------
// pcode_stack_machine_execute
// Executes one PL/0 style p-code instruction per input transaction against a
// word stack held in a synchronous RAM; returns the next fetch address.
// ---------------------------------------------------------------------------
//  channel  | handshake          | payload
//  in       | in_valid/in_stall  | function_code, level, operand
//  out      | out_valid/out_stall| next_pc, top_value, top_index, halted, fault
//
// Each instruction steps through its states in order: the static link walk
// (LOD/STO/CAL), the operand reads, execute, a divide loop for DIV, the
// write-back, the top read and the result; the single stack RAM (one read
// port, one write port, registered read) serialises these. After reset a
// clearing pass writes zero to all 4096 words and in_stall stays high
// meanwhile. A stalled result does not block the next instruction; that one
// waits in its final state until the result register is free.

`include "pcode_stack_machine_execute_macros.svh"

module pcode_stack_machine_execute (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   function_code,
  input  logic [1:0]                   level,
  input  logic [pcsm_pkg::PCW-1:0]     operand,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pcsm_pkg::PCW-1:0]     next_pc,
  output logic signed [pcsm_pkg::WB-1:0] top_value,
  output logic signed [pcsm_pkg::TW-1:0] top_index,
  output logic                         halted,
  output logic [1:0]                   fault
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_WALKW, S_RA, S_RB, S_EX, S_DIV, S_DIVF,
    S_WR, S_FIN, S_OUT
  } state_t;

  localparam int AW  = pcsm_pkg::AW;
  localparam int WB  = pcsm_pkg::WB;
  localparam int PCW = pcsm_pkg::PCW;
  localparam int TW  = pcsm_pkg::TW;
  localparam int IW  = pcsm_pkg::IW;
  localparam int DCW = pcsm_pkg::DCW;

  function automatic logic in_rng(input logic signed [IW-1:0] i);
    return i[IW-1:AW] == '0;
  endfunction

  // architectural state
  state_t                state;
  logic [AW-1:0]         clr_cnt;
  logic [PCW-1:0]        pc;
  logic [AW-1:0]         fb;
  logic signed [TW-1:0]  top;

  // current instruction
  logic [2:0]            fc;
  logic [1:0]            lev;
  logic [PCW-1:0]        opa;
  logic [PCW-1:0]        pn;
  logic signed [IW-1:0]  b1;
  logic [1:0]            k;
  logic                  walk_ok;
  logic                  x_ok, y_ok;
  logic [WB-1:0]         xw;
  logic                  fdiv, fidx, fovf;

  // pending writes
  logic [AW-1:0]         wa [3];
  logic [WB-1:0]         wd [3];
  logic [2:0]            wv;
  logic [1:0]            ws;

  // divider
  logic [WB-1:0]         dv_rem, dv_quo, dv_den;
  logic [DCW-1:0]        dv_cnt;
  logic                  dv_sign;
  logic [WB+1:0]         dv_trial;

  // stack RAM
  logic [WB-1:0]         mem [pcsm_pkg::STACK_DEPTH];
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [WB-1:0]         mem_wdata, rdata;

  // decode
  logic signed [IW-1:0]  tx, fbx, opx, r0, r1;
  logic                  need0, need1, is_bin;
  logic [WB-1:0]         yv;

  assign tx  = {{(IW-TW){top[TW-1]}}, top};
  assign fbx = {{(IW-AW){1'b0}}, fb};
  assign opx = {{(IW-PCW){1'b0}}, opa};
  assign yv  = y_ok ? rdata : '0;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    is_bin = (opa inside {[pcsm_pkg::OPR_ADD:pcsm_pkg::OPR_DIV],
                          [pcsm_pkg::OPR_EQ:pcsm_pkg::OPR_LE]});
    r0 = tx;
    r1 = tx;
    need0 = 1'b0;
    need1 = 1'b0;
    case (fc)
      pcsm_pkg::FC_OPR: begin
        if (opa == pcsm_pkg::OPR_RET) begin
          r0 = fbx + IW'(2);
          r1 = fbx + IW'(1);
          need0 = 1'b1;
          need1 = 1'b1;
        end else if (opa == pcsm_pkg::OPR_NEG || opa == pcsm_pkg::OPR_ODD) begin
          need0 = 1'b1;
        end else if (is_bin) begin
          r0 = tx - IW'(1);
          need0 = 1'b1;
          need1 = 1'b1;
        end
      end
      pcsm_pkg::FC_LOD: begin
        r0 = b1 + opx;
        need0 = walk_ok;
      end
      pcsm_pkg::FC_STO, pcsm_pkg::FC_JPC: need0 = 1'b1;
      default: ;
    endcase
  end

  // execute step
  logic signed [IW-1:0]  ex_t;
  logic [PCW-1:0]        ex_pn;
  logic                  ex_fb_ld, ex_fidx, ex_fdiv, ex_div_go;
  logic [AW-1:0]         ex_fb;
  logic signed [IW-1:0]  ex_addr [3];
  logic [WB-1:0]         ex_data [3];
  logic [2:0]            ex_use, ex_wv;
  logic signed [IW-1:0]  nb;
  logic [WB-1:0]         binres;

  always_comb begin
    ex_fdiv   = 1'b0;
    ex_div_go = 1'b0;
    case (opa)
      pcsm_pkg::OPR_ADD: binres = xw + yv;
      pcsm_pkg::OPR_SUB: binres = xw - yv;
      pcsm_pkg::OPR_MUL: binres = xw * yv;
      pcsm_pkg::OPR_DIV: begin
        binres = '0;
        if (yv == '0) begin
          ex_fdiv = 1'b1;
        end else if (yv == '1) begin
          binres = '0 - xw;
        end else begin
          ex_div_go = 1'b1;
        end
      end
      pcsm_pkg::OPR_EQ: binres = WB'(xw == yv);
      pcsm_pkg::OPR_NE: binres = WB'(xw != yv);
      pcsm_pkg::OPR_LT: binres = WB'($signed(xw) <  $signed(yv));
      pcsm_pkg::OPR_GE: binres = WB'($signed(xw) >= $signed(yv));
      pcsm_pkg::OPR_GT: binres = WB'($signed(xw) >  $signed(yv));
      default:          binres = WB'($signed(xw) <= $signed(yv));
    endcase
    if (!(fc == pcsm_pkg::FC_OPR && is_bin)) begin
      ex_fdiv   = 1'b0;
      ex_div_go = 1'b0;
    end
  end

  always_comb begin
    ex_t     = tx;
    ex_pn    = pn;
    ex_fb_ld = 1'b0;
    ex_fb    = fb;
    ex_fidx  = 1'b0;
    ex_use   = '0;
    nb       = {{(IW-WB){yv[WB-1]}}, yv};
    for (int i = 0; i < 3; i++) begin
      ex_addr[i] = '0;
      ex_data[i] = '0;
    end
    case (fc)
      pcsm_pkg::FC_LIT: begin
        ex_t = tx + IW'(1);
        ex_use[0] = 1'b1;
        ex_addr[0] = tx + IW'(1);
        ex_data[0] = WB'(opa);
      end
      pcsm_pkg::FC_OPR: begin
        if (opa == pcsm_pkg::OPR_RET) begin
          ex_t  = fbx - IW'(1);
          ex_pn = xw[PCW-1:0];
          if (in_rng(nb)) begin
            ex_fb_ld = 1'b1;
            ex_fb    = nb[AW-1:0];
          end else begin
            ex_fidx = 1'b1;
          end
        end else if (opa == pcsm_pkg::OPR_NEG) begin
          ex_use[0] = 1'b1;
          ex_addr[0] = tx;
          ex_data[0] = '0 - xw;
        end else if (opa == pcsm_pkg::OPR_ODD) begin
          ex_use[0] = 1'b1;
          ex_addr[0] = tx;
          ex_data[0] = WB'(xw[0]);
        end else if (is_bin) begin
          ex_t = tx - IW'(1);
          ex_use[0] = 1'b1;
          ex_addr[0] = tx - IW'(1);
          ex_data[0] = binres;
        end
      end
      pcsm_pkg::FC_LOD: begin
        ex_t = tx + IW'(1);
        ex_use[0] = 1'b1;
        ex_addr[0] = tx + IW'(1);
        ex_data[0] = xw;
      end
      pcsm_pkg::FC_STO: begin
        ex_t = tx - IW'(1);
        ex_use[0] = walk_ok;
        ex_addr[0] = b1 + opx;
        ex_data[0] = xw;
      end
      pcsm_pkg::FC_CAL: begin
        ex_use = 3'b111;
        ex_addr[0] = tx + IW'(1);
        ex_data[0] = walk_ok ? b1[WB-1:0] : '0;
        ex_addr[1] = tx + IW'(2);
        ex_data[1] = WB'(fb);
        ex_addr[2] = tx + IW'(3);
        ex_data[2] = WB'(pn);
        ex_pn = opa;
        if (in_rng(tx + IW'(1))) begin
          ex_fb_ld = 1'b1;
          ex_fb    = tx[AW-1:0] + AW'(1);
        end else begin
          ex_fidx = 1'b1;
        end
      end
      pcsm_pkg::FC_INT: ex_t = tx + opx;
      pcsm_pkg::FC_JMP: ex_pn = opa;
      pcsm_pkg::FC_JPC: begin
        if (xw != '0) ex_pn = opa;
        ex_t = tx - IW'(1);
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      ex_wv[i] = ex_use[i] && in_rng(ex_addr[i]);
      if (ex_use[i] && !in_rng(ex_addr[i])) ex_fidx = 1'b1;
    end
  end

  assign dv_trial = {1'b0, dv_rem, dv_quo[WB-1]} - {2'b00, dv_den};

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wa[ws];
    mem_wdata = wd[ws];
    mem_re    = 1'b0;
    mem_raddr = r0[AW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_WALK: begin
        mem_re    = (k != lev) && in_rng(b1);
        mem_raddr = b1[AW-1:0];
      end
      S_RA: mem_re = need0 && in_rng(r0);
      S_RB: begin
        mem_re    = need1 && in_rng(r1);
        mem_raddr = r1[AW-1:0];
      end
      S_WR: mem_we = wv[ws];
      S_FIN: begin
        mem_re    = !top[TW-1];
        mem_raddr = top[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      pc        <= '0;
      fb        <= '0;
      top       <= '1;
      out_valid <= 1'b0;
    end else begin
      // S_OUT reloads the result register itself
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            fc      <= function_code;
            lev     <= level;
            opa     <= operand;
            pn      <= pc + PCW'(1);
            b1      <= fbx;
            k       <= '0;
            walk_ok <= 1'b1;
            fdiv    <= 1'b0;
            fidx    <= 1'b0;
            fovf    <= 1'b0;
            if (function_code == pcsm_pkg::FC_LOD || function_code == pcsm_pkg::FC_STO ||
                function_code == pcsm_pkg::FC_CAL) begin
              state <= S_WALK;
            end else begin
              state <= S_RA;
            end
          end
        end
        S_WALK: begin
          if (k == lev) begin
            state <= S_RA;
          end else if (!in_rng(b1)) begin
            fidx    <= 1'b1;
            walk_ok <= 1'b0;
            state   <= S_RA;
          end else begin
            state <= S_WALKW;
          end
        end
        S_WALKW: begin
          b1    <= {{(IW-WB){rdata[WB-1]}}, rdata};
          k     <= k + 2'd1;
          state <= S_WALK;
        end
        S_RA: begin
          x_ok <= need0 && in_rng(r0);
          if (need0 && !in_rng(r0)) fidx <= 1'b1;
          state <= S_RB;
        end
        S_RB: begin
          xw   <= x_ok ? rdata : '0;
          y_ok <= need1 && in_rng(r1);
          if (need1 && !in_rng(r1)) fidx <= 1'b1;
          state <= S_EX;
        end
        S_EX: begin
          pn <= ex_pn;
          pc <= ex_pn;
          if (ex_fb_ld) fb <= ex_fb;
          for (int i = 0; i < 3; i++) begin
            wa[i] <= ex_addr[i][AW-1:0];
            wd[i] <= ex_data[i];
          end
          wv <= ex_wv;
          ws <= '0;
          if (ex_fidx) fidx <= 1'b1;
          if (ex_fdiv) fdiv <= 1'b1;
          // saturate the new top
          if (!ex_t[IW-1] && ex_t[IW-2:AW] != '0) begin
            fovf <= 1'b1;
            top  <= TW'(pcsm_pkg::STACK_DEPTH - 1);
          end else if (ex_t[IW-1] && ex_t != '1) begin
            fidx <= 1'b1;
            top  <= '1;
          end else begin
            top <= ex_t[TW-1:0];
          end
          if (ex_div_go) begin
            dv_rem  <= '0;
            dv_quo  <= xw[WB-1] ? '0 - xw : xw;
            dv_den  <= yv[WB-1] ? '0 - yv : yv;
            dv_sign <= xw[WB-1] ^ yv[WB-1];
            dv_cnt  <= '0;
            state   <= S_DIV;
          end else begin
            state <= S_WR;
          end
        end
        S_DIV: begin
          if (!dv_trial[WB+1]) begin
            dv_rem <= dv_trial[WB-1:0];
            dv_quo <= {dv_quo[WB-2:0], 1'b1};
          end else begin
            dv_rem <= {dv_rem[WB-2:0], dv_quo[WB-1]};
            dv_quo <= {dv_quo[WB-2:0], 1'b0};
          end
          dv_cnt <= dv_cnt + DCW'(1);
          if (dv_cnt == DCW'(WB - 1)) state <= S_DIVF;
        end
        S_DIVF: begin
          wd[0] <= dv_sign ? '0 - dv_quo : dv_quo;
          state <= S_WR;
        end
        S_WR: begin
          ws <= ws + 2'd1;
          if (ws == 2'd2 || fc != pcsm_pkg::FC_CAL) state <= S_FIN;
        end
        S_FIN: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            next_pc   <= pc;
            top_value <= top[TW-1] ? '0 : rdata;
            top_index <= top;
            halted    <= (pc == '0);
            fault     <= fovf ? pcsm_pkg::FAULT_OVF :
                         fidx ? pcsm_pkg::FAULT_IDX :
                         fdiv ? pcsm_pkg::FAULT_DIV : pcsm_pkg::FAULT_NONE;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PCSM_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && !in_stall, state != S_IDLE, "accepted transaction did not start")
  `PCSM_ASSERT_NOW(a_top_floor, clk, rst, state != S_CLEAR, $signed(top) >= -13'sd1, "top index below empty")
  `PCSM_ASSERT_NEXT(a_no_overwrite, clk, rst, state == S_OUT && out_valid && out_stall, state == S_OUT, "result overwritten while stalled")

endmodule
